// ===== design/gimbal_point_to_servo_pulses_assert.svh =====
// Assertion macros shared by the gimbal pointing block.
// Every macro samples on clk_i and stays quiet while rst_ni is low.
`ifndef GIMBAL_POINT_TO_SERVO_PULSES_ASSERT_SVH
`define GIMBAL_POINT_TO_SERVO_PULSES_ASSERT_SVH

// The consequence holds in the same cycle as the antecedent.
`define GPTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define GPTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gpts_pkg.sv =====
// ----------------------------------------------------------------------------
// gpts_pkg
// Types, constants and the arctangent table of the gimbal pointing block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gpts_pkg;

  // Port field widths
  localparam int POS_W      = 16;
  localparam int PULSE_W    = 16;
  localparam int ANGDEG_W   = 9;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Angles are degrees in Q16, wide enough for offset angles up to 1024 deg
  localparam int ANG_W     = 27;
  localparam int FRAC_Q    = 16;
  localparam int GUARD     = 8;
  localparam int INV_GAIN  = 39797;
  localparam int TBL_LEN   = 24;
  localparam int GAIN_W    = 17;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 8'd3;

  // Register reset values
  localparam logic [ANGDEG_W-1:0] RST_MIN_ANGLE = 9'd0;
  localparam logic [ANGDEG_W-1:0] RST_MAX_ANGLE = 9'd180;
  localparam logic [PULSE_W-1:0]  RST_MIN_PULSE = 16'd500;
  localparam logic [PULSE_W-1:0]  RST_MAX_PULSE = 16'd2500;

  // atan(2^-i) in degrees, Q16
  localparam logic signed [ANG_W-1:0] ATAN_TBL [TBL_LEN] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
    27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
    27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
    27'sd917,     27'sd458,     27'sd229,    27'sd115,
    27'sd57,      27'sd29,      27'sd14,     27'sd7,
    27'sd4,       27'sd2,       27'sd1,      27'sd0
  };

  localparam logic signed [ANG_W-1:0] DEG90_Q16 = 27'sd5898240;

  typedef struct packed {
    logic [ANGDEG_W-1:0] min_ang;
    logic [ANGDEG_W-1:0] max_ang;
    logic [PULSE_W-1:0]  min_pulse;
    logic [PULSE_W-1:0]  max_pulse;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/gpts_if.sv =====
// ----------------------------------------------------------------------------
// gpts_if
// Request channels of the gimbal pointing block: position in, pulses out and
// register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gpts_in_if import gpts_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface gpts_out_if import gpts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] pan_pulse;
  logic [PULSE_W-1:0] tilt_pulse;
  modport source (output valid, pan_pulse, tilt_pulse, input ready);
  modport sink   (input valid, pan_pulse, tilt_pulse, output ready);
endinterface

interface gpts_cfg_if import gpts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/gpts_cordic.sv =====
// ----------------------------------------------------------------------------
// gpts_cordic
// Pipelined vectoring CORDIC with quadrant pre-rotation: angle of (x, y) in
// degrees Q16 and the unscaled magnitude, one register stage per iteration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpts_cordic import gpts_pkg::*; #(
  parameter int XW     = 27,
  parameter int STAGES = 16,
  parameter int SW     = 27
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [XW-1:0]    x_i,
  input  logic signed [XW-1:0]    y_i,
  input  logic [SW-1:0]           side_i,
  output logic                    valid_o,
  output logic signed [ANG_W-1:0] ang_o,
  output logic signed [XW-1:0]    mag_o,
  output logic [SW-1:0]           side_o
);

  logic signed [XW-1:0]    x_q   [STAGES+1];
  logic signed [XW-1:0]    y_q   [STAGES+1];
  logic signed [ANG_W-1:0] acc_q [STAGES+1];
  logic [SW-1:0]           side_q[STAGES+1];
  logic                    zero_q[STAGES+1];
  logic                    vld_q [STAGES+1];

  logic signed [XW-1:0]    x0_d, y0_d;
  logic signed [ANG_W-1:0] acc0_d;

  // Rotate the left half plane into the right half plane
  always_comb begin
    x0_d   = x_i;
    y0_d   = y_i;
    acc0_d = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0_d   = y_i;
        y0_d   = -x_i;
        acc0_d = DEG90_Q16;
      end else begin
        x0_d   = -y_i;
        y0_d   = x_i;
        acc0_d = -DEG90_Q16;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0_d;
      y_q[0]    <= y0_d;
      acc_q[0]  <= acc0_d;
      side_q[0] <= side_i;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  // One micro-rotation per stage, driving y toward zero
  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    logic signed [XW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] >= 0) begin
          x_q[i+1]   <= x_q[i] + ys;
          y_q[i+1]   <= y_q[i] - xs;
          acc_q[i+1] <= acc_q[i] + ATAN_TBL[i];
        end else begin
          x_q[i+1]   <= x_q[i] - ys;
          y_q[i+1]   <= y_q[i] + xs;
          acc_q[i+1] <= acc_q[i] - ATAN_TBL[i];
        end
        side_q[i+1] <= side_q[i];
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  // The origin has angle zero; its magnitude is zero by itself
  assign valid_o = vld_q[STAGES];
  assign ang_o   = zero_q[STAGES] ? '0 : acc_q[STAGES];
  assign mag_o   = x_q[STAGES];
  assign side_o  = side_q[STAGES];

endmodule

`default_nettype wire

// ===== design/gpts_pulse.sv =====
// ----------------------------------------------------------------------------
// gpts_pulse
// Maps an angle onto a servo pulse width: offset, round, clamp to the angle
// limits, linear map with a pipelined restoring divider, clamp to the pulse
// limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpts_pulse import gpts_pkg::*; #(
  parameter int AF         = 8,
  parameter int OFFSET_DEG = 90
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [ANG_W-1:0] ang_i,
  input  cfg_t                    cfg_i,
  output logic                    valid_o,
  output logic [PULSE_W-1:0]      pulse_o
);

  localparam int SH  = FRAC_Q - AF;
  localparam int AW  = ANG_W - SH;
  localparam int LW  = ANGDEG_W + AF;
  localparam int DW  = LW + PULSE_W;
  localparam int NW  = DW + 2;
  localparam int RND = (2 ** SH) / 2;
  localparam logic signed [ANG_W-1:0] OFS =
    ANG_W'(OFFSET_DEG * (2 ** FRAC_Q) + RND);

  // Limits in angle units, span and pulse delta follow the registers
  logic [LW-1:0]          lo, hi, den;
  logic signed [AW-1:0]   lo_x, hi_x;
  logic signed [PULSE_W:0] pdelta;
  logic                   degen;

  assign lo     = {cfg_i.min_ang, AF'(0)};
  assign hi     = {cfg_i.max_ang, AF'(0)};
  assign den    = hi - lo;
  assign lo_x   = $signed({2'b00, lo});
  assign hi_x   = $signed({2'b00, hi});
  assign pdelta = $signed({1'b0, cfg_i.max_pulse}) - $signed({1'b0, cfg_i.min_pulse});
  assign degen  = cfg_i.max_ang <= cfg_i.min_ang;

  // Stage 1: add offset and rounding bias
  logic signed [ANG_W-1:0] sum_q;
  logic                    v1_q;

  // Stage 2: round, clamp, distance from the low limit
  logic signed [AW-1:0] a_s;
  logic [LW-1:0]        clamp_d;
  logic [LW-1:0]        diff_q;
  logic                 v2_q;

  assign a_s = $signed(sum_q[ANG_W-1:SH]);

  always_comb begin
    if (a_s < lo_x) begin
      clamp_d = lo;
    end else if (a_s > hi_x) begin
      clamp_d = hi;
    end else begin
      clamp_d = a_s[LW-1:0];
    end
  end

  // Stage 3: the two products of the linear map
  logic [DW-1:0]        m1_q;
  logic signed [NW-1:0] m2_q;
  logic                 v3_q;

  // Stage 4: dividend
  logic signed [NW-1:0] num_d;
  logic [DW-1:0]        rem_q [PULSE_W+1];
  logic [PULSE_W-1:0]   quo_q [PULSE_W+1];
  logic                 vd_q  [PULSE_W+1];

  assign num_d = $signed({2'b00, m1_q}) + m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      vd_q[0]  <= 1'b0;
    end else if (en_i) begin
      v1_q     <= valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      vd_q[0]  <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q    <= ang_i + OFS;
      diff_q   <= clamp_d - lo;
      m1_q     <= cfg_i.min_pulse * den;
      m2_q     <= $signed({1'b0, diff_q}) * pdelta;
      rem_q[0] <= num_d[DW-1:0];
      quo_q[0] <= '0;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 0; j < PULSE_W; j++) begin : g_div
    localparam int K = PULSE_W - 1 - j;
    logic [DW-1:0] dsh;
    logic [DW:0]   trial;
    assign dsh   = DW'(den) << K;
    assign trial = {1'b0, rem_q[j]} - {1'b0, dsh};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vd_q[j+1] <= vd_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!trial[DW]) begin
          rem_q[j+1] <= trial[DW-1:0];
          quo_q[j+1] <= quo_q[j] | (PULSE_W'(1) << K);
        end else begin
          rem_q[j+1] <= rem_q[j];
          quo_q[j+1] <= quo_q[j];
        end
      end
    end
  end

  // Clamp low first, then high; an angle range with max not above min gives the low pulse
  always_comb begin
    pulse_o = quo_q[PULSE_W];
    if (pulse_o < cfg_i.min_pulse) begin
      pulse_o = cfg_i.min_pulse;
    end
    if (pulse_o > cfg_i.max_pulse) begin
      pulse_o = cfg_i.max_pulse;
    end
    if (degen) begin
      pulse_o = cfg_i.min_pulse;
    end
  end

  assign valid_o = vd_q[PULSE_W];

endmodule

`default_nettype wire

// ===== design/gimbal_point_to_servo_pulses.sv =====
// Throughput: one request per cycle while the skid entry is free; the two CORDIC
// pipelines and two 16-stage divider pipelines each take a new item every such cycle.
// A two-entry output buffer lets the pipeline run while a result waits.
// Reset: asynchronous, active low; clears valid bits and loads the register
// defaults (angles 0..180, pulses 500..2500).
// ----------------------------------------------------------------------------
// gimbal_point_to_servo_pulses
// Target position to pan and tilt servo pulse widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gimbal_point_to_servo_pulses_assert.svh"

module gimbal_point_to_servo_pulses import gpts_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_WIDTH   = 16,
  parameter int ANGLE_FRAC    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gpts_in_if.sink     in_i,
  gpts_out_if.source  out_o,
  gpts_cfg_if.sink    cfg_i
);

  localparam int XW = COORD_WIDTH + GUARD + 3;
  localparam int PW = XW + GAIN_W;
  localparam logic signed [GAIN_W-1:0] GAIN_S = GAIN_W'(INV_GAIN);
  localparam logic signed [PW-1:0]     HALF_Q = PW'(2 ** (FRAC_Q - 1));

  // Configuration registers
  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_ang   <= RST_MIN_ANGLE;
      cfg_q.max_ang   <= RST_MAX_ANGLE;
      cfg_q.min_pulse <= RST_MIN_PULSE;
      cfg_q.max_pulse <= RST_MAX_PULSE;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MIN_ANGLE: cfg_q.min_ang   <= cfg_i.data[ANGDEG_W-1:0];
        REG_MAX_ANGLE: cfg_q.max_ang   <= cfg_i.data[ANGDEG_W-1:0];
        REG_MIN_PULSE: cfg_q.min_pulse <= cfg_i.data;
        REG_MAX_PULSE: cfg_q.max_pulse <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Pipeline advances while the skid entry is free
  logic skid_vq;
  logic en;
  assign en         = !skid_vq;
  assign in_i.ready = en;

  // Input stage: sign-extend the used coordinate bits, add guard bits
  logic [2*POS_W-1:0]   ext_x, ext_y, ext_z;
  logic signed [XW-1:0] x_a_q, y_a_q, z_a_q;
  logic                 va_q;

  assign ext_x = {POS_W'(0), in_i.pos_x};
  assign ext_y = {POS_W'(0), in_i.pos_y};
  assign ext_z = {POS_W'(0), in_i.pos_z};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_a_q <= XW'($signed(ext_x[COORD_WIDTH-1:0])) <<< GUARD;
      y_a_q <= XW'($signed(ext_y[COORD_WIDTH-1:0])) <<< GUARD;
      z_a_q <= XW'($signed(ext_z[COORD_WIDTH-1:0])) <<< GUARD;
    end
  end

  // Pan angle and raw horizontal magnitude
  logic                    pan_v;
  logic signed [ANG_W-1:0] pan_ang;
  logic signed [XW-1:0]    pan_mag;
  logic [XW-1:0]           pan_z;

  gpts_cordic #(.XW(XW), .STAGES(CORDIC_STAGES), .SW(XW)) u_pan_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (va_q),
    .x_i     (x_a_q),
    .y_i     (y_a_q),
    .side_i  (z_a_q),
    .valid_o (pan_v),
    .ang_o   (pan_ang),
    .mag_o   (pan_mag),
    .side_o  (pan_z)
  );

  // Gain correction: multiply, then round half up
  logic signed [PW-1:0]    prod_q;
  logic signed [PW-1:0]    prod_rnd;
  logic signed [ANG_W-1:0] pan_m_q, pan_r_q;
  logic signed [XW-1:0]    z_m_q, z_r_q, d_q;
  logic                    vm_q, vr_q;

  assign prod_rnd = prod_q + HALF_Q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vr_q <= 1'b0;
    end else if (en) begin
      vm_q <= pan_v;
      vr_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q  <= pan_mag * GAIN_S;
      pan_m_q <= pan_ang;
      z_m_q   <= $signed(pan_z);
      d_q     <= XW'(prod_rnd >>> FRAC_Q);
      pan_r_q <= pan_m_q;
      z_r_q   <= z_m_q;
    end
  end

  // Tilt angle from horizontal distance and height
  logic                    tilt_v;
  logic signed [ANG_W-1:0] tilt_ang;
  logic signed [XW-1:0]    tilt_mag;
  logic [ANG_W-1:0]        pan_t;

  gpts_cordic #(.XW(XW), .STAGES(CORDIC_STAGES), .SW(ANG_W)) u_tilt_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vr_q),
    .x_i     (d_q),
    .y_i     (z_r_q),
    .side_i  (pan_r_q),
    .valid_o (tilt_v),
    .ang_o   (tilt_ang),
    .mag_o   (tilt_mag),
    .side_o  (pan_t)
  );

  // Angle to pulse mapping, one unit per servo
  logic               pan_pv, tilt_pv;
  logic [PULSE_W-1:0] pan_pulse, tilt_pulse;

  gpts_pulse #(.AF(ANGLE_FRAC), .OFFSET_DEG(90)) u_pan_pulse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tilt_v),
    .ang_i   ($signed(pan_t)),
    .cfg_i   (cfg_q),
    .valid_o (pan_pv),
    .pulse_o (pan_pulse)
  );

  gpts_pulse #(.AF(ANGLE_FRAC), .OFFSET_DEG(120)) u_tilt_pulse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tilt_v),
    .ang_i   (tilt_ang),
    .cfg_i   (cfg_q),
    .valid_o (tilt_pv),
    .pulse_o (tilt_pulse)
  );

  // Output register with one skid entry
  logic               last_v;
  logic               out_vq;
  logic [PULSE_W-1:0] out_pan_q, out_tilt_q, skid_pan_q, skid_tilt_q;
  logic               load_out;

  assign last_v   = pan_pv & tilt_pv & en;
  assign load_out = !out_vq || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else if (load_out) begin
      out_vq  <= skid_vq | last_v;
      skid_vq <= 1'b0;
    end else if (last_v) begin
      skid_vq <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_pan_q  <= skid_vq ? skid_pan_q  : pan_pulse;
      out_tilt_q <= skid_vq ? skid_tilt_q : tilt_pulse;
    end else if (last_v) begin
      skid_pan_q  <= pan_pulse;
      skid_tilt_q <= tilt_pulse;
    end
  end

  assign out_o.valid      = out_vq;
  assign out_o.pan_pulse  = out_pan_q;
  assign out_o.tilt_pulse = out_tilt_q;

  // Checks on the output buffer and on the alignment of the two pulse units
  `GPTS_ASSERT_SAME(a_skid_behind_out, skid_vq, out_vq, "skid entry full with output empty")
  `GPTS_ASSERT_NEXT(a_out_held, out_vq && !out_o.ready, out_vq, "stalled result dropped")
  `GPTS_ASSERT_NEXT(a_skid_held, skid_vq && !out_o.ready, skid_vq && !in_i.ready,
                    "skid entry lost or input taken while full")
  `GPTS_ASSERT_SAME(a_units_aligned, pan_pv != tilt_pv, 1'b0 && tilt_mag == tilt_mag,
                    "pulse units out of step")

endmodule

`default_nettype wire
